### sv/hrrs_pkg.sv
// ----------------------------------------------------------------------------
// hrrs_pkg: shared types and constants of the response-ratio scheduler
// Holds the job record layout, the sequencer state type and the fixed
// widths of the priority divider.
// ----------------------------------------------------------------------------
package hrrs_pkg;

   // request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // divider: (wait << 8) / burst, one quotient bit per cycle
   localparam int FRAC_W    = 8;
   localparam int NUM_W     = 16 + FRAC_W;
   localparam int DIV_STEPS = NUM_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // hybrid priority (base + 256 + q) / 2 fits in 24 bits
   localparam int SUM_W  = NUM_W + 1;
   localparam int PRIO_W = SUM_W - 1;
   localparam logic [SUM_W-1:0] RATIO_ONE = SUM_W'(1 << FRAC_W);

   localparam logic [15:0] WAIT_MAX = 16'hFFFF;

   // one job record as stored in the table
   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [15:0] base;
      logic [15:0] wait_cnt;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DIV,
      ST_CMP,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_DONE
   } state_type;

endpackage

### sv/hybrid_response_ratio_scheduler_core.sv
// ----------------------------------------------------------------------------
// hybrid_response_ratio_scheduler_core: preemptive response-ratio scheduler
// Keeps a table of jobs. A load request fills a slot; a tick request picks
// the arrived live job with the highest hybrid priority, runs it for one
// unit, ages the other jobs that arrived before the current time and reports a finishing job.
// ----------------------------------------------------------------------------
//
//   chan | dir | handshake             | payload
//   -----+-----+-----------------------+-----------------------------------------------------
//   req  | in  | req_valid / req_ready | kind, slot, arrival, burst, base_priority
//   rsp  | out | rsp_valid / rsp_ready | ran_valid, ran_slot, finished, wait_total, turnaround
//
// a load request writes its slot directly; a tick scans every slot, runs the
// one-bit-per-cycle divider shared by all slots for each arrived live job, and
// sweeps every slot once more to update it when a job runs.
// req_ready is high only while the sequencer is idle; the response register
// lets the next request in while the previous response waits on rsp_ready.
// synchronous active-high reset clears live bits, time and control state.
// ----------------------------------------------------------------------------
module hybrid_response_ratio_scheduler_core
   import hrrs_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_arrival,
   input  logic [15:0] req_burst,
   input  logic [15:0] req_base_priority,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ran_valid,
   output logic [3:0]  rsp_ran_slot,
   output logic        rsp_finished,
   output logic [15:0] rsp_wait_total,
   output logic [15:0] rsp_turnaround
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   // job table
   job_type mem [SLOTS];
   job_type rd_data_ff;

   logic              mem_we;
   logic [SLOT_W-1:0] mem_wa;
   job_type           mem_wd;

   state_type state_ff, state_in;

   logic [SLOTS-1:0]  live_ff, live_in;
   logic [15:0]       cur_time_ff, cur_time_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] chosen_ff, chosen_in;
   logic              found_ff, found_in;
   logic [PRIO_W-1:0] best_ff, best_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [15:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic              fin_ff, fin_in;
   logic [15:0]       fin_wait_ff, fin_wait_in;
   logic [15:0]       fin_turn_ff, fin_turn_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ran_valid_ff;
   logic [3:0]        rsp_ran_slot_ff;
   logic              rsp_finished_ff;
   logic [15:0]       rsp_wait_total_ff;
   logic [15:0]       rsp_turnaround_ff;

   logic              req_fire;
   logic              scan_last;
   logic              eligible;
   logic              rsp_free;
   logic              div_last;
   logic [16:0]       div_shift;
   logic [17:0]       div_diff;
   logic [SUM_W-1:0]  prio_sum;
   logic [PRIO_W-1:0] prio;
   logic              load_in_range;
   job_type           upd_rec;
   logic [15:0]       upd_rem;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign scan_last = (idx_ff == LAST_SLOT);
   assign eligible  = live_ff[idx_ff] && (rd_data_ff.arrival <= cur_time_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign div_last  = (div_cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign load_in_range = (32'(req_slot) < SLOTS);

   // shared divider step: shift in one numerator bit, trial subtract burst
   assign div_shift = {rem_ff, num_ff[NUM_W-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, rd_data_ff.burst};

   // hybrid priority from the finished quotient
   assign prio_sum = {{(SUM_W-16){1'b0}}, rd_data_ff.base} + RATIO_ONE
                     + {1'b0, num_ff};
   assign prio     = prio_sum[SUM_W-1:1];

   // record update for the sweep after the pick
   always_comb begin
      upd_rec = rd_data_ff;
      upd_rem = rd_data_ff.remaining;
      if (idx_ff == chosen_ff) begin
         if (rd_data_ff.remaining != 16'd0) begin
            upd_rem = rd_data_ff.remaining - 16'd1;
         end
         upd_rec.remaining = upd_rem;
      end else if (live_ff[idx_ff] && (rd_data_ff.arrival < cur_time_ff)
                   && (rd_data_ff.wait_cnt != WAIT_MAX)) begin
         upd_rec.wait_cnt = rd_data_ff.wait_cnt + 16'd1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_kind == KIND_TICK) ? ST_SCAN_RD : ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (eligible) begin
               state_in = ST_DIV;
            end else if (scan_last) begin
               state_in = found_ff ? ST_UPD_RD : ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = scan_last ? ST_UPD_RD : ST_SCAN_RD;
         end
         ST_UPD_RD: begin
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            state_in = scan_last ? ST_DONE : ST_UPD_RD;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and table control
   always_comb begin
      live_in      = live_ff;
      cur_time_in  = cur_time_ff;
      idx_in       = idx_ff;
      chosen_in    = chosen_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      fin_in       = fin_ff;
      fin_wait_in  = fin_wait_ff;
      fin_turn_in  = fin_turn_ff;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = upd_rec;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in      = '0;
               chosen_in   = '0;
               found_in    = 1'b0;
               fin_in      = 1'b0;
               fin_wait_in = 16'd0;
               fin_turn_in = 16'd0;
               // load writes the record straight into the table
               if ((req_kind == KIND_LOAD) && load_in_range) begin
                  mem_we             = 1'b1;
                  mem_wa             = SLOT_W'(req_slot);
                  mem_wd.arrival     = req_arrival;
                  mem_wd.burst       = req_burst;
                  mem_wd.remaining   = req_burst;
                  mem_wd.base        = req_base_priority;
                  mem_wd.wait_cnt    = 16'd0;
                  live_in[SLOT_W'(req_slot)] = (req_burst != 16'd0);
               end
            end
         end
         ST_SCAN_CHK: begin
            if (eligible) begin
               num_in     = {rd_data_ff.wait_cnt, {FRAC_W{1'b0}}};
               rem_in     = 16'd0;
               div_cnt_in = '0;
            end else begin
               idx_in = scan_last ? '0 : idx_ff + 1'b1;
               // idle tick still advances time
               if (scan_last && !found_ff) begin
                  cur_time_in = cur_time_ff + 16'd1;
               end
            end
         end
         ST_DIV: begin
            div_cnt_in = div_cnt_ff + 1'b1;
            if (!div_diff[17]) begin
               rem_in = div_diff[15:0];
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = div_shift[15:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
         end
         ST_CMP: begin
            if (!found_ff || (prio > best_ff)) begin
               best_in   = prio;
               chosen_in = idx_ff;
               found_in  = 1'b1;
            end
            idx_in = scan_last ? '0 : idx_ff + 1'b1;
         end
         ST_UPD_WR: begin
            mem_we = 1'b1;
            if ((idx_ff == chosen_ff) && (upd_rem == 16'd0)) begin
               live_in[idx_ff] = 1'b0;
               fin_in          = 1'b1;
               fin_wait_in     = rd_data_ff.wait_cnt;
               fin_turn_in     = cur_time_ff + 16'd1 - rd_data_ff.arrival;
            end
            idx_in = scan_last ? '0 : idx_ff + 1'b1;
            if (scan_last) begin
               cur_time_in = cur_time_ff + 16'd1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // job table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[idx_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         cur_time_ff  <= 16'd0;
         found_ff     <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         cur_time_ff  <= cur_time_in;
         found_ff     <= found_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      chosen_ff   <= chosen_in;
      best_ff     <= best_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      fin_wait_ff <= fin_wait_in;
      fin_turn_ff <= fin_turn_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_ran_valid_ff  <= found_ff;
         rsp_ran_slot_ff   <= 4'(chosen_ff);
         rsp_finished_ff   <= fin_ff;
         rsp_wait_total_ff <= fin_wait_ff;
         rsp_turnaround_ff <= fin_turn_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ran_valid  = rsp_ran_valid_ff;
   assign rsp_ran_slot   = rsp_ran_slot_ff;
   assign rsp_finished   = rsp_finished_ff;
   assign rsp_wait_total = rsp_wait_total_ff;
   assign rsp_turnaround = rsp_turnaround_ff;

`ifndef SYNTHESIS
   // a finished job always comes with a job that ran
   a_fin_ran: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_finished || rsp_ran_valid))
      else $error("finished response without a running job");

   // divider count stays inside its step range
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff < CNT_W'(DIV_STEPS)))
      else $error("divider step count out of range");

   // the update sweep only runs after a job was picked
   a_upd_found: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPD_RD) || (state_ff == ST_UPD_WR)) |-> found_ff)
      else $error("update sweep without a chosen job");

   // time moves only at the end of a tick
   a_time_step: assert property (@(posedge clock) disable iff (reset)
      (cur_time_ff != $past(cur_time_ff)) |->
         (($past(state_ff) == ST_UPD_WR) || ($past(state_ff) == ST_SCAN_CHK)))
      else $error("current time changed outside the end of a tick");
`endif

endmodule

### tb/hybrid_response_ratio_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// hybrid_response_ratio_scheduler_core_tb: self-checking bench for the scheduler
// Drives load and tick requests through the valid/ready request channel and
// checks every response against a cycle-free model of the job table or a typed
// directed expectation. A short directed table covers field extremes, ties,
// zero-burst clears, reloads and idle ticks. Random traffic follows: mostly job
// batches arriving near the current time, followed by runs of ticks, plus fully
// random noise requests. Both sides idle in short bursts, and the response side
// stalls once for a long stretch so that the block backs up into its request port.
// ----------------------------------------------------------------------------
module hybrid_response_ratio_scheduler_core_tb;
   import hrrs_pkg::*;

   localparam int NUM_SLOTS   = 16;
   localparam int ITEMS       = 1170;
   localparam int QUIET_TAIL  = 150;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 600;
   localparam int DIR_ROWS    = 25;

   typedef struct packed {
      logic        ran_valid;
      logic [3:0]  ran_slot;
      logic        finished;
      logic [15:0] wait_total;
      logic [15:0] turnaround;
   } sched_rsp_t;

   typedef struct packed {
      logic        kind;
      logic [3:0]  slot;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] base;
      logic        typed;
      sched_rsp_t  want;
   } sched_req_t;

   localparam sched_rsp_t NO_RSP = '0;

   // directed plan: kind, slot, arrival, burst, base, typed, typed response
   localparam sched_req_t DIRECTED_PLAN [DIR_ROWS] = '{
      // empty table: idle tick
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, NO_RSP},
      // one-tick job finishes at once
      '{KIND_LOAD, 4'd0,  16'h0000, 16'h0001, 16'h0000, 1'b1, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{1'b1, 4'd0, 1'b1, 16'd0, 16'd2}},
      // all-ones job that has not arrived yet
      '{KIND_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NO_RSP},
      '{KIND_TICK, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NO_RSP},
      // equal priorities: lower slot wins
      '{KIND_LOAD, 4'd3,  16'h0001, 16'h0002, 16'h0100, 1'b1, NO_RSP},
      '{KIND_LOAD, 4'd5,  16'h0001, 16'h0002, 16'h0100, 1'b1, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      // zero burst leaves the slot empty
      '{KIND_LOAD, 4'd7,  16'h0000, 16'h0000, 16'h0000, 1'b1, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      // reload of a live slot replaces the job
      '{KIND_LOAD, 4'd7,  16'h0002, 16'h0003, 16'h0000, 1'b1, NO_RSP},
      '{KIND_LOAD, 4'd7,  16'h0005, 16'h0001, 16'hFFFF, 1'b1, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      // future arrival: idle until it shows up
      '{KIND_LOAD, 4'd8,  16'h000B, 16'h0001, 16'h8000, 1'b1, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      // longest burst against a short one
      '{KIND_LOAD, 4'd1,  16'h0000, 16'hFFFF, 16'h0000, 1'b1, NO_RSP},
      '{KIND_LOAD, 4'd15, 16'h0000, 16'h0002, 16'h0000, 1'b1, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      '{KIND_TICK, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_RSP},
      '{KIND_LOAD, 4'd1,  16'h0000, 16'h0000, 16'h0000, 1'b1, NO_RSP}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_LOAD;
   logic [3:0]  req_slot = '0;
   logic [15:0] req_arrival = '0;
   logic [15:0] req_burst = '0;
   logic [15:0] req_base_priority = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ran_valid;
   logic [3:0]  rsp_ran_slot;
   logic        rsp_finished;
   logic [15:0] rsp_wait_total;
   logic [15:0] rsp_turnaround;

   // typed expectation travelling with the request on the port
   logic        req_typed = 1'b0;
   sched_rsp_t  req_want = '0;

   // model of the job table
   bit          job_live [NUM_SLOTS];
   bit [15:0]   job_arrival [NUM_SLOTS];
   bit [15:0]   job_burst [NUM_SLOTS];
   bit [15:0]   job_remaining [NUM_SLOTS];
   bit [15:0]   job_base [NUM_SLOTS];
   bit [15:0]   job_wait [NUM_SLOTS];
   bit [15:0]   sched_time = '0;

   sched_rsp_t  pending_outcomes [$];
   int          sent_count = 0;
   bit [15:0]   gen_time = '0;
   int          fail_count = 0;
   int          load_count = 0;
   int          tick_count = 0;
   int          idle_count = 0;
   int          finish_count = 0;
   int          longest_wait = 0;
   logic        hold_rsp = 1'b0;
   int          rsp_gap = 0;

   hybrid_response_ratio_scheduler_core #(.SLOTS(NUM_SLOTS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_slot          (req_slot),
      .req_arrival       (req_arrival),
      .req_burst         (req_burst),
      .req_base_priority (req_base_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ran_valid     (rsp_ran_valid),
      .rsp_ran_slot      (rsp_ran_slot),
      .rsp_finished      (rsp_finished),
      .rsp_wait_total    (rsp_wait_total),
      .rsp_turnaround    (rsp_turnaround)
   );

   always #4 clock = ~clock;

   // short idle bursts are off in a middle window and in the closing stretch
   function automatic bit idling_allowed();
      return !(sent_count >= 600 && sent_count < 700) && (sent_count < ITEMS - QUIET_TAIL);
   endfunction

   // apply one request to the job table and return the response it causes
   function automatic sched_rsp_t schedule_step(input logic kind, input logic [3:0] slot,
                                                input logic [15:0] arrival,
                                                input logic [15:0] burst,
                                                input logic [15:0] base);
      sched_rsp_t r;
      int         pick;
      bit [63:0]  top;
      bit [63:0]  prio;
      bit [15:0]  now;
      r = '0;
      pick = -1;
      top = '0;
      now = sched_time;
      if (kind == KIND_LOAD) begin
         job_live[slot] = (burst != 16'd0);
         job_arrival[slot] = arrival;
         job_burst[slot] = burst;
         job_remaining[slot] = burst;
         job_base[slot] = base;
         job_wait[slot] = '0;
         load_count++;
         return r;
      end
      tick_count++;
      // highest hybrid priority among arrived jobs, ties to the lower slot
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (job_live[i] && job_arrival[i] <= now) begin
            prio = (64'(job_base[i]) +
                    (((64'(job_burst[i]) + 64'(job_wait[i])) << 8) / 64'(job_burst[i]))) >> 1;
            if (pick < 0 || prio > top) begin
               pick = i;
               top = prio;
            end
         end
      end
      if (pick >= 0) begin
         // age the other jobs that arrived strictly earlier
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i != pick && job_live[i] && job_arrival[i] < now && job_wait[i] != 16'hFFFF)
               job_wait[i] = job_wait[i] + 16'd1;
         end
         if (job_remaining[pick] != 16'd0)
            job_remaining[pick] = job_remaining[pick] - 16'd1;
         r.ran_valid = 1'b1;
         r.ran_slot = 4'(pick);
         if (job_remaining[pick] == 16'd0) begin
            job_live[pick] = 1'b0;
            r.finished = 1'b1;
            r.wait_total = job_wait[pick];
            r.turnaround = now + 16'd1 - job_arrival[pick];
            finish_count++;
            if (int'(job_wait[pick]) > longest_wait)
               longest_wait = int'(job_wait[pick]);
         end
      end else begin
         idle_count++;
      end
      sched_time = now + 16'd1;
      return r;
   endfunction

   // offer one request and hold it until accepted
   task automatic send_request(input sched_req_t r);
      if (idling_allowed() && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= r.kind;
      req_slot <= r.slot;
      req_arrival <= r.arrival;
      req_burst <= r.burst;
      req_base_priority <= r.base;
      req_typed <= r.typed;
      req_want <= r.want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (r.kind == KIND_TICK)
         gen_time = gen_time + 16'd1;
   endtask

   // a job load shaped to arrive near the current tick, mostly with short bursts
   function automatic sched_req_t job_request();
      sched_req_t r;
      int         pick;
      r = '0;
      r.kind = KIND_LOAD;
      r.slot = 4'($urandom_range(0, NUM_SLOTS - 1));
      case ($urandom_range(0, 3))
         0: r.arrival = gen_time;
         1: r.arrival = gen_time - 16'($urandom_range(1, 8));
         2: r.arrival = gen_time + 16'($urandom_range(1, 4));
         default: r.arrival = 16'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 4)
         r.burst = '0;
      else if (pick < 80)
         r.burst = 16'($urandom_range(1, 6));
      else if (pick < 92)
         r.burst = 16'($urandom_range(7, 40));
      else
         r.burst = 16'($urandom);
      r.base = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
      return r;
   endfunction

   // request side: prediction on accept; response side: compare with oldest
   always @(posedge clock) begin
      sched_rsp_t predicted;
      sched_rsp_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ran_valid !== want.ran_valid) begin
               $error("ran_valid: expected %0d, got %0d", want.ran_valid, rsp_ran_valid);
               fail_count++;
            end
            if (rsp_ran_slot !== want.ran_slot) begin
               $error("ran_slot: expected %0d, got %0d", want.ran_slot, rsp_ran_slot);
               fail_count++;
            end
            if (rsp_finished !== want.finished) begin
               $error("finished: expected %0d, got %0d", want.finished, rsp_finished);
               fail_count++;
            end
            if (rsp_wait_total !== want.wait_total) begin
               $error("wait_total: expected %0d, got %0d", want.wait_total, rsp_wait_total);
               fail_count++;
            end
            if (rsp_turnaround !== want.turnaround) begin
               $error("turnaround: expected %0d, got %0d", want.turnaround, rsp_turnaround);
               fail_count++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         predicted = schedule_step(req_kind, req_slot, req_arrival, req_burst,
                                   req_base_priority);
         pending_outcomes.push_back(req_typed ? req_want : predicted);
      end
   end

   // response side: short random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rsp_gap <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // long stall on the response side so the block backs up into its request port
   initial begin
      while (sent_count < HOLD_AT) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("[hybrid_response_ratio_scheduler_core] ERROR");
      $finish;
   end

   // main sequence
   initial begin
      sched_req_t r;
      int         nload;
      int         nticks;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIR_ROWS; i++)
         send_request(DIRECTED_PLAN[i]);

      // random traffic: job batches followed by tick runs, with some noise
      while (sent_count < ITEMS) begin
         if ($urandom_range(0, 99) < 12) begin
            r = '0;
            r.kind = 1'($urandom_range(0, 1));
            r.slot = 4'($urandom);
            r.arrival = 16'($urandom);
            r.burst = 16'($urandom);
            r.base = 16'($urandom);
            send_request(r);
         end else begin
            nload = $urandom_range(1, 4);
            nticks = $urandom_range(1, 10);
            for (int i = 0; i < nload; i++)
               send_request(job_request());
            for (int i = 0; i < nticks; i++) begin
               r = '0;
               r.kind = KIND_TICK;
               r.slot = 4'($urandom);
               r.arrival = 16'($urandom);
               r.burst = 16'($urandom);
               r.base = 16'($urandom);
               send_request(r);
            end
         end
      end
      req_valid <= 1'b0;

      // drain outstanding responses, then let the block settle
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d job loads and %0d ticks, %0d of the ticks idle",
               load_count, tick_count, idle_count);
      $display("%0d jobs ran to completion, longest reported wait %0d ticks",
               finish_count, longest_wait);
      if (fail_count == 0) begin
         $display("[hybrid_response_ratio_scheduler_core] OK");
      end else begin
         $display("[hybrid_response_ratio_scheduler_core] ERROR");
      end
      $finish;
   end

endmodule

### files.f
sv/hrrs_pkg.sv
sv/hybrid_response_ratio_scheduler_core.sv
tb/hybrid_response_ratio_scheduler_core_tb.sv
